// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each macro samples on clk and is disabled while
// rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle
`define AWBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle
`define AWBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/awbd_pkg.sv -----
// ----------------------------------------------------------------------------
// awbd_pkg
// Widths and the per-cell transaction record of the alpha-weighted box
// downsampler.
// ----------------------------------------------------------------------------
package awbd_pkg;

    localparam int TEXEL_W = 32;              // packed source texel
    localparam int BYTE_W  = 8;               // one channel or alpha
    localparam int TEX_N   = 4;               // texels in a 2x2 footprint
    localparam int CH_N    = 3;               // color channels
    localparam int ASUM_W  = 10;              // sum of four alphas, max 1020
    localparam int WSUM_W  = 18;              // sum of four c*a, max 260100
    localparam int QUO_W   = 8;               // quotient bits, one per cell
    localparam int ALPHA_SH = 2;              // out alpha = asum / 4

    // Record handed from cell to cell
    typedef struct packed {
        logic [ASUM_W-1:0]                asum;  // divisor
        logic [CH_N-1:0][WSUM_W-1:0]      rem;   // partial remainders
        logic [CH_N-1:0][QUO_W-1:0]       quo;   // quotient bits so far
    } cell_data_t;

endpackage

// ----- sv/alpha_weighted_box_downsample.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_box_downsample
// 2x2 box filter with alpha-weighted color: each color channel is
// sum(c*a)/sum(a) truncated (zero when all alphas are zero), alpha is
// floor(sum(a)/4).
// Usage:
//   Input channel: in_valid / in_stall with the four packed texels of one
//   footprint (alpha in bits 31:24). A transaction is taken at a clock edge
//   with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with one texel per input
//   transaction, in order.
//   Path: from input transaction to out_valid through one sum stage,
//   eight divider cells and one output register.
//   Throughput: one transaction per cycle while out_stall is low; every stage
//   is a pipeline register and each divider cell resolves one quotient bit.
//   Stall: a stalled output holds its payload; transactions collapse into
//   empty stages behind it, and in_stall rises only when all ten stages hold
//   a transaction and the output is stalled.
//   Reset: all stages are emptied; nothing in flight survives.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alpha_weighted_box_downsample
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] texel_top_left,
    input  logic [31:0] texel_top_right,
    input  logic [31:0] texel_bottom_left,
    input  logic [31:0] texel_bottom_right,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_channel0,
    output logic [7:0]  out_channel1,
    output logic [7:0]  out_channel2,
    output logic [7:0]  out_alpha
);

    localparam int QW    = awbd_pkg::QUO_W;
    localparam int BW    = awbd_pkg::BYTE_W;
    localparam int AW    = awbd_pkg::ASUM_W;
    localparam int WW    = awbd_pkg::WSUM_W;

    // Chain links: link 0 leaves the sum stage, link QW leaves the last cell
    awbd_pkg::cell_data_t link_data [0:QW];
    logic                 link_vld  [0:QW];
    logic                 link_rdy  [0:QW];

    logic                 front_rdy;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [BW-1:0]        ch0_reg;
    logic [BW-1:0]        ch1_reg;
    logic [BW-1:0]        ch2_reg;
    logic [BW-1:0]        alpha_reg;
    logic                 out_load;
    logic                 asum_zero;
    logic                 chain_full;
    logic                 quo_fits;
    logic                 rem_done;
    logic                 out_hold;
    logic [4*BW:0]        out_word;

    // Sum stage
    awbd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .tex_tl   (texel_top_left),
        .tex_tr   (texel_top_right),
        .tex_bl   (texel_bottom_left),
        .tex_br   (texel_bottom_right),
        .up_ready (front_rdy),
        .dn_valid (link_vld[0]),
        .dn_data  (link_data[0]),
        .dn_ready (link_rdy[0])
    );

    assign in_stall = !front_rdy;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        awbd_div_cell
        #(
            .BIT_POS (QW - 1 - k)
        )
        u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_vld[k]),
            .up_data  (link_data[k]),
            .up_ready (link_rdy[k]),
            .dn_valid (link_vld[k+1]),
            .dn_data  (link_data[k+1]),
            .dn_ready (link_rdy[k+1])
        );
    end

    // Output register
    assign link_rdy[QW]  = !out_vld_reg || !out_stall;
    assign out_load      = link_rdy[QW] && link_vld[QW];
    assign out_vld_next  = link_rdy[QW] ? link_vld[QW] : out_vld_reg;
    assign asum_zero     = (link_data[QW].asum == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    // Zero alpha sum forces zero color (the chain yields all ones there)
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ch0_reg   <= asum_zero ? '0 : link_data[QW].quo[0];
            ch1_reg   <= asum_zero ? '0 : link_data[QW].quo[1];
            ch2_reg   <= asum_zero ? '0 : link_data[QW].quo[2];
            alpha_reg <= link_data[QW].asum[AW-1 -: BW];
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_channel0 = ch0_reg;
    assign out_channel1 = ch1_reg;
    assign out_channel2 = ch2_reg;
    assign out_alpha    = alpha_reg;

    // Checker terms: full chain, quotient range at entry, remainder at exit
    assign chain_full = out_valid && out_stall && link_vld[0] && link_vld[QW];
    assign out_hold   = out_valid && out_stall;
    assign out_word   = {out_valid, out_channel0, out_channel1, out_channel2, out_alpha};

    always_comb
    begin
        quo_fits = 1'b1;
        rem_done = 1'b1;
        for (int c = 0; c < awbd_pkg::CH_N; c++)
        begin
            if (link_data[0].rem[c] >= (WW'(link_data[0].asum) << QW))
                quo_fits = 1'b0;
            if (link_data[QW].rem[c] >= WW'(link_data[QW].asum))
                rem_done = 1'b0;
        end
        // zero alpha sum: no division takes place
        if (link_data[0].asum == '0)
            quo_fits = 1'b1;
        if (asum_zero)
            rem_done = 1'b1;
    end

    // Assertions
    `AWBD_ASSERT_SAME(a_stall_only_when_full, in_stall, chain_full, "input stalled with room")
    `AWBD_ASSERT_SAME(a_quotient_fits, link_vld[0], quo_fits, "weighted sum out of range")
    `AWBD_ASSERT_SAME(a_remainder_done, link_vld[QW], rem_done, "remainder not below divisor")
    `AWBD_ASSERT_NEXT(a_held_output_kept, out_hold, $stable(out_word), "stalled output changed")

endmodule

// ----- sv/awbd_front.sv -----
// ----------------------------------------------------------------------------
// awbd_front
// Unpacks the four texels, forms the alpha sum and the alpha-weighted color
// sums, and registers them as the first transaction of the divider chain.
// ----------------------------------------------------------------------------
module awbd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    input  logic [awbd_pkg::TEXEL_W-1:0]  tex_tl,
    input  logic [awbd_pkg::TEXEL_W-1:0]  tex_tr,
    input  logic [awbd_pkg::TEXEL_W-1:0]  tex_bl,
    input  logic [awbd_pkg::TEXEL_W-1:0]  tex_br,
    output logic                          up_ready,
    output logic                          dn_valid,
    output awbd_pkg::cell_data_t          dn_data,
    input  logic                          dn_ready
);

    localparam int BW = awbd_pkg::BYTE_W;
    localparam int AW = awbd_pkg::ASUM_W;
    localparam int WW = awbd_pkg::WSUM_W;

    logic [awbd_pkg::TEX_N-1:0][awbd_pkg::TEXEL_W-1:0] tex;
    logic                 vld_reg;
    logic                 vld_next;
    awbd_pkg::cell_data_t data_reg;
    awbd_pkg::cell_data_t data_next;

    assign tex = {tex_br, tex_bl, tex_tr, tex_tl};

    // Products and sums; the quotient bits start clear
    always_comb
    begin
        logic [BW-1:0]   alpha;
        logic [BW-1:0]   chan;
        logic [2*BW-1:0] prod;
        data_next = '0;
        for (int t = 0; t < awbd_pkg::TEX_N; t++)
        begin
            alpha = tex[t][4*BW-1 -: BW];
            data_next.asum = data_next.asum + AW'(alpha);
            for (int c = 0; c < awbd_pkg::CH_N; c++)
            begin
                chan = tex[t][c*BW +: BW];
                prod = chan * alpha;
                data_next.rem[c] = data_next.rem[c] + WW'(prod);
            end
        end
    end

    // Stage handshake: load when empty or when the next cell takes ours
    assign up_ready = !vld_reg || dn_ready;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

// ----- sv/awbd_div_cell.sv -----
// ----------------------------------------------------------------------------
// awbd_div_cell
// One cell of the restoring divider chain: resolves quotient bit BIT_POS for
// all three channels and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module awbd_div_cell
#(
    parameter int BIT_POS = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  awbd_pkg::cell_data_t up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output awbd_pkg::cell_data_t dn_data,
    input  logic                 dn_ready
);

    localparam int WW = awbd_pkg::WSUM_W;

    logic                 vld_reg;
    logic                 vld_next;
    awbd_pkg::cell_data_t data_reg;
    awbd_pkg::cell_data_t data_next;
    logic [WW-1:0]        div_shifted;

    // Divisor aligned to this cell's quotient bit
    assign div_shifted = WW'(up_data.asum) << BIT_POS;

    // Trial subtract per channel
    always_comb
    begin
        data_next = up_data;
        for (int c = 0; c < awbd_pkg::CH_N; c++)
        begin
            if (up_data.rem[c] >= div_shifted)
            begin
                data_next.rem[c]          = up_data.rem[c] - div_shifted;
                data_next.quo[c][BIT_POS] = 1'b1;
            end
        end
    end

    // Stage handshake
    assign up_ready = !vld_reg || dn_ready;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

// ----- verif/tb_alpha_weighted_box_downsample.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_alpha_weighted_box_downsample
// Self-checking bench for the alpha-weighted 2x2 box downsampler. Footprints
// go in through the valid/stall channel and are predicted in the bench. Each
// output texel is compared per field with the oldest predicted texel. Both
// channels idle and stall at random, with one stretch at full rate and one
// pause until the pipeline has drained.
// ============================================================================
module tb_alpha_weighted_box_downsample;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_PCT    = 34;
    localparam int PIPE_DEPTH  = 10;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_PRINTS  = 40;

    // One downsampled texel as the block presents it
    typedef struct packed {
        logic [awbd_pkg::BYTE_W-1:0] ch0;
        logic [awbd_pkg::BYTE_W-1:0] ch1;
        logic [awbd_pkg::BYTE_W-1:0] ch2;
        logic [awbd_pkg::BYTE_W-1:0] alpha;
    } mip_texel_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [awbd_pkg::TEXEL_W-1:0] texel_top_left;
    logic [awbd_pkg::TEXEL_W-1:0] texel_top_right;
    logic [awbd_pkg::TEXEL_W-1:0] texel_bottom_left;
    logic [awbd_pkg::TEXEL_W-1:0] texel_bottom_right;
    logic                         out_valid;
    logic                         out_stall;
    logic [awbd_pkg::BYTE_W-1:0]  out_channel0;
    logic [awbd_pkg::BYTE_W-1:0]  out_channel1;
    logic [awbd_pkg::BYTE_W-1:0]  out_channel2;
    logic [awbd_pkg::BYTE_W-1:0]  out_alpha;

    mip_texel_t expected_texels[$];
    int         error_count;
    int         footprints_sent;
    int         texels_checked;
    int         zero_alpha_seen;
    bit         full_rate;        // no idling on either side while set

    alpha_weighted_box_downsample DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .texel_top_left     (texel_top_left),
        .texel_top_right    (texel_top_right),
        .texel_bottom_left  (texel_bottom_left),
        .texel_bottom_right (texel_bottom_right),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_channel0       (out_channel0),
        .out_channel1       (out_channel1),
        .out_channel2       (out_channel2),
        .out_alpha          (out_alpha)
    );

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Known values on every input from time zero
    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        out_stall          = 1'b0;
        texel_top_left     = '0;
        texel_top_right    = '0;
        texel_bottom_left  = '0;
        texel_bottom_right = '0;
        full_rate          = 1'b0;
        error_count        = 0;
        footprints_sent    = 0;
        texels_checked     = 0;
        zero_alpha_seen    = 0;
    end

    // Alpha-weighted average of one footprint, exact integer division
    function automatic mip_texel_t box_average(
        input logic [awbd_pkg::TEX_N-1:0][awbd_pkg::TEXEL_W-1:0] quad);
        logic [awbd_pkg::ASUM_W-1:0] asum;
        logic [awbd_pkg::WSUM_W-1:0] wsum [awbd_pkg::CH_N];
        logic [awbd_pkg::WSUM_W-1:0] quo  [awbd_pkg::CH_N];
        logic [awbd_pkg::BYTE_W-1:0] a;
        mip_texel_t                  r;
        asum = '0;
        for (int c = 0; c < awbd_pkg::CH_N; c++)
            wsum[c] = '0;
        for (int t = 0; t < awbd_pkg::TEX_N; t++)
        begin
            a = quad[t][31:24];
            asum += a;
            for (int c = 0; c < awbd_pkg::CH_N; c++)
                wsum[c] += quad[t][8*c +: 8] * a;
        end
        for (int c = 0; c < awbd_pkg::CH_N; c++)
        begin
            quo[c] = '0;
            if (asum != 0)
            begin
                quo[c] = wsum[c] / asum;
                if (quo[c] > 255)
                    quo[c] = 255;
            end
        end
        r.ch0   = quo[0][7:0];
        r.ch1   = quo[1][7:0];
        r.ch2   = quo[2][7:0];
        r.alpha = asum[awbd_pkg::ASUM_W-1:awbd_pkg::ALPHA_SH];
        return r;
    endfunction

    // One line per mismatch, printing capped
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Send one footprint; random idle cycles ahead of it
    task automatic send_footprint(input logic [awbd_pkg::TEXEL_W-1:0] tl,
                                  input logic [awbd_pkg::TEXEL_W-1:0] tr,
                                  input logic [awbd_pkg::TEXEL_W-1:0] bl,
                                  input logic [awbd_pkg::TEXEL_W-1:0] br);
        logic [awbd_pkg::TEX_N-1:0][awbd_pkg::TEXEL_W-1:0] quad;
        @(negedge clk);
        while (!full_rate && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        texel_top_left     <= tl;
        texel_top_right    <= tr;
        texel_bottom_left  <= bl;
        texel_bottom_right <= br;
        // wait for the transaction
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quad = {br, bl, tr, tl};
        expected_texels.push_back(box_average(quad));
        footprints_sent++;
        if (tl[31:24] == 0 && tr[31:24] == 0 && bl[31:24] == 0 && br[31:24] == 0)
            zero_alpha_seen++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Random texel with extreme alphas and channel bytes well represented
    function automatic logic [awbd_pkg::TEXEL_W-1:0] shaped_texel();
        logic [awbd_pkg::TEXEL_W-1:0] t;
        t = $urandom;
        case ($urandom_range(4))
            0: t[31:24] = 8'h00;
            1: t[31:24] = 8'hFF;
            2: t[31:24] = 8'h01;
            default: ;
        endcase
        for (int c = 0; c < awbd_pkg::CH_N; c++)
        begin
            case ($urandom_range(3))
                0: t[8*c +: 8] = 8'h00;
                1: t[8*c +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return t;
    endfunction

    // Output side: random stall
    always @(negedge clk)
        out_stall <= !full_rate && ($urandom_range(99) < IDLE_PCT);

    // Compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        mip_texel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_texels.size() == 0)
            begin
                report_mismatch($sformatf("output %02h %02h %02h %02h with nothing pending",
                                          out_channel0, out_channel1, out_channel2, out_alpha));
            end
            else
            begin
                want = expected_texels.pop_front();
                texels_checked++;
                if (out_channel0 !== want.ch0)
                    report_mismatch($sformatf("texel %0d channel0 %02h, want %02h",
                                              texels_checked, out_channel0, want.ch0));
                if (out_channel1 !== want.ch1)
                    report_mismatch($sformatf("texel %0d channel1 %02h, want %02h",
                                              texels_checked, out_channel1, want.ch1));
                if (out_channel2 !== want.ch2)
                    report_mismatch($sformatf("texel %0d channel2 %02h, want %02h",
                                              texels_checked, out_channel2, want.ch2));
                if (out_alpha !== want.alpha)
                    report_mismatch($sformatf("texel %0d alpha %02h, want %02h",
                                              texels_checked, out_alpha, want.alpha));
            end
        end
    end

    // Extremes and the zero-alpha case
    task automatic test_directed();
        send_footprint(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_footprint(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // colors with all alphas zero give zero
        send_footprint(32'h00FF_FFFF, 32'h0012_3456, 32'h00AB_CDEF, 32'h00FF_FFFF);
        // single barely visible texel carries the color
        send_footprint(32'h01FF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_footprint(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h01FF_FFFF);
        // opaque texel among transparent ones of other color
        send_footprint(32'h0055_AA33, 32'hFF12_3456, 32'h00FF_FFFF, 32'h0080_8080);
        send_footprint(32'h01F0_0F55, 32'h0110_2030, 32'h01FF_0000, 32'h0100_FFFF);
        send_footprint(32'hFF00_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'hFFFF_FFFF);
        send_footprint(32'h0311_2233, 32'h0344_5566, 32'h0377_8899, 32'h03AA_BBCC);
        // alpha sum below four floors to zero
        send_footprint(32'h01FF_0000, 32'h0100_FF00, 32'h0100_00FF, 32'h0000_0000);
        send_footprint(32'h8011_2233, 32'h8011_2233, 32'h8011_2233, 32'h8011_2233);
        // heavy weight against a light one
        send_footprint(32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000);
        send_footprint(32'hFE00_0000, 32'h01FF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_footprint(32'h7FFF_00FF, 32'h3F00_FF00, 32'h1FFF_FF00, 32'h0F00_00FF);
        send_footprint(32'hFFFF_FFFF, 32'hFEFF_FFFF, 32'hFDFF_FFFF, 32'hFCFF_FFFF);
        send_footprint(32'hAA55_AA55, 32'h55AA_55AA, 32'hAA55_AA55, 32'h55AA_55AA);
    endtask

    // Fully random words
    task automatic test_random_words(input int count);
        repeat (count)
            send_footprint($urandom, $urandom, $urandom, $urandom);
    endtask

    // Footprints biased toward transparent, opaque and faint texels
    task automatic test_shaped_footprints(input int count);
        repeat (count)
            send_footprint(shaped_texel(), shaped_texel(), shaped_texel(), shaped_texel());
    endtask

    // Hold off until the pipeline is empty, then resume
    task automatic test_drain_pause(input int count);
        test_shaped_footprints(count);
        release_input();
        while (expected_texels.size() != 0)
            @(posedge clk);
        test_random_words(count);
    endtask

    // Back-to-back transactions, no stall on either side
    task automatic test_full_rate(input int count);
        full_rate = 1'b1;
        test_shaped_footprints(count);
        release_input();
        full_rate = 1'b0;
    endtask

    // Run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Sequence
    initial
    begin
        int waited;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_words(300);
        test_shaped_footprints(300);
        test_drain_pause(50);
        test_full_rate(200);
        test_shaped_footprints(120);
        release_input();

        // let the pipeline drain
        waited = 0;
        while (expected_texels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_texels.size() != 0)
            report_mismatch($sformatf("%0d texels never came out", expected_texels.size()));
        repeat (3 * PIPE_DEPTH) @(posedge clk);

        $display("Sent %0d footprints (%0d fully transparent), checked %0d output texels,",
                 footprints_sent, zero_alpha_seen, texels_checked);
        $display("with random stalls on both sides, a full-rate burst and one drain pause.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
